// ===== design/packed_vector_fold_macros.svh =====
// Assertion macros shared by the packed vector fold design files.
`ifndef PACKED_VECTOR_FOLD_MACROS_SVH
`define PACKED_VECTOR_FOLD_MACROS_SVH
`ifndef NO_ASSERTIONS
// Antecedent implies consequent in the same cycle.
`define PVF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Antecedent implies consequent in the following cycle.
`define PVF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PVF_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define PVF_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== design/pvf_pkg.sv =====
// Shared constants, types and helpers of the packed vector fold.
package pvf_pkg;

  localparam int WORD_W   = 64;
  localparam int LEN_W    = 27;
  localparam int EBITS_W  = 7;
  localparam int NIB_W    = 5;   // nibble counts 0..16
  localparam int NIB_PER_WORD = WORD_W / 4;
  localparam int OUT_FIELDS_W = 2 * WORD_W + LEN_W + EBITS_W + 1;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Header start positions in nibbles.
  localparam logic [NIB_W-1:0] SMALL_HDR_NIB = 5'd2;
  localparam logic [NIB_W-1:0] BIG_HDR_NIB   = 5'd8;
  localparam logic [NIB_W-1:0] WORD_NIB      = 5'd16;

  // Control from the sequencer to the extract unit.
  typedef struct packed {
    logic load;        // take a new word into the shift register
    logic clear_part;  // drop any partial element (new vector)
    logic step;        // extract one piece of an element
  } ext_ctrl_t;

  // Status from the extract unit back to the sequencer.
  typedef struct packed {
    logic complete;    // this step finishes an element
    logic word_end;    // this step uses the last bits of the word
  } ext_stat_t;

  // Control of the max/sum accumulator.
  typedef struct packed {
    logic clear;
    logic add;
  } acc_ctrl_t;

  // Mask of the low n nibbles of a word.
  function automatic logic [WORD_W-1:0] nib_mask(input logic [NIB_W-1:0] n);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int i = 0; i < NIB_PER_WORD; i++) begin
      if (NIB_W'(i) < n) begin
        m[4*i +: 4] = 4'hf;
      end
    end
    return m;
  endfunction

endpackage

// ===== design/pvf_extract.sv =====
// Shift-based element extractor: one element piece per cycle in which step is asserted.
`include "packed_vector_fold_macros.svh"
module pvf_extract (
  input  logic                            clk,
  input  logic                            rst,
  input  pvf_pkg::ext_ctrl_t              ctrl,
  input  logic [pvf_pkg::WORD_W-1:0]      word,
  input  logic [pvf_pkg::NIB_W-1:0]       start_nib,
  input  logic [pvf_pkg::NIB_W-1:0]       width_nib,
  output pvf_pkg::ext_stat_t              stat,
  output logic [pvf_pkg::WORD_W-1:0]      elem
);

  logic [pvf_pkg::WORD_W-1:0] word_reg;
  logic [pvf_pkg::WORD_W-1:0] partial;
  logic [pvf_pkg::NIB_W-1:0]  pos;
  logic [3:0]                 pbits;

  logic [pvf_pkg::NIB_W-1:0]  need;
  logic [pvf_pkg::NIB_W-1:0]  avail;
  logic [pvf_pkg::NIB_W-1:0]  take;
  logic [pvf_pkg::NIB_W-1:0]  pbits_sum;
  logic [pvf_pkg::NIB_W-1:0]  pos_sum;
  logic [pvf_pkg::WORD_W-1:0] chunk;

  // Size of the next piece: what the element still needs, limited by the word.
  always_comb begin
    need      = width_nib - {1'b0, pbits};
    avail     = pvf_pkg::WORD_NIB - pos;
    take      = (need < avail) ? need : avail;
    pbits_sum = {1'b0, pbits} + take;
    pos_sum   = pos + take;
    chunk     = word_reg & pvf_pkg::nib_mask(take);
    elem      = partial | (chunk << {pbits, 2'b00});
    stat.complete = (pbits_sum == width_nib);
    stat.word_end = (pos_sum == pvf_pkg::WORD_NIB);
  end

  // Word shift register and partial element.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      pbits <= '0;
    end else begin
      if (ctrl.load) begin
        word_reg <= word >> {start_nib, 2'b00};
        pos      <= start_nib;
      end else if (ctrl.step) begin
        word_reg <= word_reg >> {take, 2'b00};
        pos      <= pos_sum;
      end
      if (ctrl.clear_part || (ctrl.step && stat.complete)) begin
        partial <= '0;
        pbits   <= '0;
      end else if (ctrl.step) begin
        partial <= elem;
        pbits   <= pbits_sum[3:0];
      end
    end
  end

  `PVF_ASSERT_NOW(a_step_room, clk, rst, ctrl.step, pos < pvf_pkg::WORD_NIB, "step past word end")
  `PVF_ASSERT_NOW(a_step_part, clk, rst, ctrl.step, ({1'b0, pbits} < width_nib), "partial overflow")
  `PVF_ASSERT_NEXT(a_load_pos, clk, rst, ctrl.load, pos < pvf_pkg::WORD_NIB, "bad load position")

endmodule

// ===== design/pvf_accum.sv =====
// Running maximum and modulo sum of the unpacked elements.
module pvf_accum (
  input  logic                        clk,
  input  pvf_pkg::acc_ctrl_t          ctrl,
  input  logic [pvf_pkg::WORD_W-1:0]  elem,
  output logic [pvf_pkg::WORD_W-1:0]  max_next,
  output logic [pvf_pkg::WORD_W-1:0]  sum_next
);

  logic [pvf_pkg::WORD_W-1:0] run_max;
  logic [pvf_pkg::WORD_W-1:0] run_sum;

  // One compare and one add per element.
  always_comb begin
    max_next = run_max;
    sum_next = run_sum;
    if (ctrl.add) begin
      max_next = (elem > run_max) ? elem : run_max;
      sum_next = run_sum + elem;
    end
  end

  // Cleared at each header so results need no reset value.
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      run_max <= '0;
      run_sum <= '0;
    end else begin
      run_max <= max_next;
      run_sum <= sum_next;
    end
  end

endmodule

// ===== design/packed_vector_fold.sv =====
// Top level of the packed vector fold: sequencer, extract unit, accumulator.
//
// Each 64-bit word is accepted while the block is idle and then worked
// through one element piece per cycle, unless the output stalls, by a shared
// shift-and-mask extract unit feeding a compare/add accumulator; a word
// holds up to 16 element pieces, for 4-bit elements. The header of an empty
// vector holds no piece and posts its result from the run state. An element
// that straddles two words takes one piece from each. The result of a
// vector waits in an output register; the block keeps working on the next
// vector and stalls only when a new result is due while the previous one
// has not yet been taken.
`include "packed_vector_fold_macros.svh"
module packed_vector_fold (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [pvf_pkg::WORD_W-1:0]         s_tdata,   // word[63:0]
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // max_value[63:0], total[127:64], length[154:128], element_bits[161:155],
  // big_format[162], zero fill[167:163]
  output logic [pvf_pkg::OUT_TDATA_W-1:0]    m_tdata
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                         state;
  logic                         expect_header;
  logic [pvf_pkg::LEN_W-1:0]    remaining;
  logic [pvf_pkg::LEN_W-1:0]    len_seen;
  logic [pvf_pkg::NIB_W-1:0]    width_nib;
  logic                         is_big;

  logic                         accept;
  logic                         out_free;
  logic                         last;
  logic                         emit;
  logic                         step;
  logic                         hdr_big;
  logic [3:0]                   hdr_reso;
  logic [pvf_pkg::LEN_W-1:0]    hdr_len;
  logic [pvf_pkg::NIB_W-1:0]    start_nib;

  pvf_pkg::ext_ctrl_t           ext_ctrl;
  pvf_pkg::ext_stat_t           ext_stat;
  pvf_pkg::acc_ctrl_t           acc_ctrl;
  logic [pvf_pkg::WORD_W-1:0]   elem;
  logic [pvf_pkg::WORD_W-1:0]   max_next;
  logic [pvf_pkg::WORD_W-1:0]   sum_next;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Header decode straight from the incoming word.
  always_comb begin
    hdr_big  = s_tdata[0];
    hdr_reso = hdr_big ? s_tdata[4:1] : {2'b00, s_tdata[2:1]};
    hdr_len  = hdr_big ? s_tdata[31:5] : {22'd0, s_tdata[7:3]};
    if (!expect_header) begin
      start_nib = '0;
    end else if (hdr_big) begin
      start_nib = pvf_pkg::BIG_HDR_NIB;
    end else begin
      start_nib = pvf_pkg::SMALL_HDR_NIB;
    end
  end

  // Sequencer decisions for the current cycle.
  always_comb begin
    last = ext_stat.complete && (remaining == pvf_pkg::LEN_W'(1));
    step = 1'b0;
    emit = 1'b0;
    if (state == ST_RUN) begin
      if (remaining == '0) begin
        emit = out_free;
      end else begin
        step = !last || out_free;
        emit = last && out_free;
      end
    end
    ext_ctrl.load       = accept;
    ext_ctrl.clear_part = accept && expect_header;
    ext_ctrl.step       = step;
    acc_ctrl.clear      = accept && expect_header;
    acc_ctrl.add        = step && ext_stat.complete;
  end

  // Vector state and sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      expect_header <= 1'b1;
      remaining     <= '0;
      len_seen      <= '0;
      width_nib     <= 5'd1;
      is_big        <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_RUN;
            if (expect_header) begin
              expect_header <= 1'b0;
              is_big        <= hdr_big;
              len_seen      <= hdr_len;
              remaining     <= hdr_len;
              width_nib     <= {1'b0, hdr_reso} + 5'd1;
            end
          end
        end
        ST_RUN: begin
          if (step && ext_stat.complete) begin
            remaining <= remaining - pvf_pkg::LEN_W'(1);
          end
          if (emit) begin
            expect_header <= 1'b1;
            state         <= ST_IDLE;
          end else if (step && ext_stat.word_end) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {(pvf_pkg::OUT_TDATA_W - pvf_pkg::OUT_FIELDS_W)'(0),
                  is_big, {width_nib, 2'b00}, len_seen, sum_next, max_next};
    end
  end

  pvf_extract u_extract (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ext_ctrl),
    .word      (s_tdata),
    .start_nib (start_nib),
    .width_nib (width_nib),
    .stat      (ext_stat),
    .elem      (elem)
  );

  pvf_accum u_accum (
    .clk      (clk),
    .ctrl     (acc_ctrl),
    .elem     (elem),
    .max_next (max_next),
    .sum_next (sum_next)
  );

  `PVF_ASSERT_NEXT(a_emit_valid, clk, rst, emit, m_tvalid && expect_header, "result not posted")
  `PVF_ASSERT_NOW(a_emit_free, clk, rst, emit, out_free, "result overwritten")
  `PVF_ASSERT_NOW(a_empty_run, clk, rst, state == ST_RUN && remaining == '0, !expect_header, "empty run state")

endmodule
